@@ sv/arcl_pkg.sv @@
// ============================================================================
// arcl_pkg
// Types and constants shared by the row cluster legalizer.
// ============================================================================
package arcl_pkg;

    localparam int MaxCells = 1024;
    localparam int SlotW    = 10;

    localparam logic [1:0] REQ_TRY    = 2'd0;
    localparam logic [1:0] REQ_COMMIT = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;   // unused code; answered with a zeroed result, stack unchanged

    localparam logic [1:0] ADDR_ROW_X_MIN  = 2'd0;
    localparam logic [1:0] ADDR_ROW_X_MAX  = 2'd1;
    localparam logic [1:0] ADDR_SITE_PITCH = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] cell_x;
        logic [15:0] cell_width;
        logic [11:0] cell_height;
    } in_item_t;

    typedef struct packed {
        logic        placed;
        logic [23:0] cell_new_x;
        logic [23:0] cluster_x;
        logic [9:0]  cluster_slot;
        logic [48:0] x_cost;
    } out_item_t;

    // one stack entry: q, weight, width, pos, index of the cluster's last cell
    typedef struct packed {
        logic [63:0] q;
        logic [39:0] weight;
        logic [23:0] width;
        logic [23:0] pos;
        logic [9:0]  tail_idx;
    } clus_entry_t;

endpackage

@@ sv/arcl_div.sv @@
// ============================================================================
// arcl_div
// Radix-2 restoring divider for unsigned operands, one quotient bit a cycle.
// ============================================================================
module arcl_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;

    assign trial    = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == 7'd0);

    // shift and subtract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
            rem_reg  <= 64'd0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

@@ sv/abacus_row_cluster_legalizer.sv @@
// ============================================================================
// abacus_row_cluster_legalizer
// Abacus cluster engine for one row segment: append, place, collapse.
// ============================================================================
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | arcl_pkg::in_item_t
//  out     | output    | out_valid/out_stall| arcl_pkg::out_item_t
//  cfg     | input     | APB write/read     | row_x_min, row_x_max, site pitch
//
// Most of a placement pass is spent in two runs of the shared divider
// (q/weight, then the site snap); a zero-weight cluster skips the first
// run. Each merge adds another pass, and setup and wrap-up states surround
// the passes. A clear or an unused request code answers with a zeroed
// result from the S_ZERO state.
// Reset clears the stack count and control; memory contents are undefined.
// A stalled result is held in the output register; no new item is taken
// until it leaves.
module abacus_row_cluster_legalizer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  arcl_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output arcl_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDTOP = 4'd1;
    localparam logic [3:0] S_TOP   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_SNAP  = 4'd6;
    localparam logic [3:0] S_DIV2  = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_RDPRV = 4'd9;
    localparam logic [3:0] S_PRV   = 4'd10;
    localparam logic [3:0] S_MERGE = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_COST  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_ZERO  = 4'd15;

    localparam logic signed [65:0] Lim = 66'sd1 << 40;

    logic [23:0] row_x_min_reg;
    logic [23:0] row_x_max_reg;
    logic [15:0] site_pitch_reg;

    logic [3:0]  state_reg;
    logic [10:0] count_reg;
    arcl_pkg::in_item_t  item_reg;
    arcl_pkg::out_item_t out_reg;
    logic        out_valid_reg;

    // cluster stack memory
    arcl_pkg::clus_entry_t mem [arcl_pkg::MaxCells];
    arcl_pkg::clus_entry_t rd_reg;
    logic [9:0]  rd_addr;
    logic        wr_en;

    logic [63:0] q_reg;
    logic [50:0] wt_reg;
    logic [24:0] wd_reg;
    logic [9:0]  last_reg;
    logic signed [11:0] prev_reg;
    logic [27:0] w_reg;
    logic signed [65:0] x_reg;
    logic signed [65:0] rel_reg;
    logic [1:0]  mstep_reg;
    logic [63:0] pa_reg;
    logic [63:0] pb_reg;

    logic        div_start;
    logic [63:0] div_a;
    logic [63:0] div_b;
    logic        div_done;
    logic [63:0] div_q;

    arcl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [25:0] span;
    logic signed [25:0] hi;
    logic [15:0] site;
    logic        qneg;
    logic [63:0] qabs;
    logic signed [65:0] quo_s;
    logic signed [65:0] rel_min;
    logic [24:0] prv_end;
    logic [51:0] mul_wx;
    logic [52:0] mul_wd;
    logic [49:0] mul_lo;
    logic [48:0] mul_hi;
    logic [56:0] snap_prod;
    logic [63:0] cost_sq;

    assign span    = $signed({2'b0, row_x_max_reg}) - $signed({2'b0, row_x_min_reg});
    assign hi      = $signed({2'b0, row_x_max_reg}) - $signed({1'b0, wd_reg});
    assign site    = (site_pitch_reg == 16'd0) ? 16'd1 : site_pitch_reg;
    assign qneg    = q_reg[63];
    assign qabs    = qneg ? (~q_reg + 64'd1) : q_reg;
    assign quo_s   = qneg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    assign rel_min = x_reg - $signed({42'd0, row_x_min_reg});
    assign prv_end = {1'b0, rd_reg.pos} + {1'b0, rd_reg.width};

    // products, each kept within a single-cycle multiplier
    assign mul_wx    = w_reg * item_reg.cell_x;
    assign mul_wd    = w_reg * wd_reg;
    assign mul_lo    = wt_reg[25:0] * rd_reg.width;
    assign mul_hi    = wt_reg[50:26] * rd_reg.width;
    assign snap_prod = div_q[40:0] * site;
    assign cost_sq   = pa_reg[31:0] * pa_reg[31:0];

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_a     = qabs;
        div_b     = {13'd0, wt_reg};
        if (state_reg == S_CHK && span >= $signed({1'b0, wd_reg}) && wt_reg != '0)
            div_start = 1'b1;
        if (state_reg == S_SNAP && x_reg >= $signed({42'd0, row_x_min_reg}))
            div_start = 1'b1;
        if (state_reg == S_SNAP)
        begin
            div_a = rel_min[63:0];
            div_b = {48'd0, site};
        end
    end

    // memory read address
    always_comb
    begin
        rd_addr = count_reg[9:0] - 10'd1;
        if (state_reg == S_CLAMP || state_reg == S_RDPRV || state_reg == S_PRV
            || state_reg == S_MERGE)
            rd_addr = prev_reg[9:0];
    end

    assign wr_en = (state_reg == S_FIN) && (item_reg.req_type == arcl_pkg::REQ_COMMIT)
                   && (prev_reg < 12'sd1023);

    // stack memory, registered read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (wr_en)
            mem[prev_reg[9:0] + 10'd1] <= '{q: q_reg, weight: wt_reg[39:0],
                                             width: wd_reg[23:0], pos: x_reg[23:0],
                                             tail_idx: last_reg};
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_min_reg  <= 24'd0;
            row_x_max_reg  <= 24'hFFFFFF;
            site_pitch_reg <= 16'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                arcl_pkg::ADDR_ROW_X_MIN:  row_x_min_reg  <= pwdata[23:0];
                arcl_pkg::ADDR_ROW_X_MAX:  row_x_max_reg  <= pwdata[23:0];
                arcl_pkg::ADDR_SITE_PITCH: site_pitch_reg <= pwdata[15:0];
                default:                   ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (paddr[3:2])
            arcl_pkg::ADDR_ROW_X_MIN:  prdata = {8'd0, row_x_min_reg};
            arcl_pkg::ADDR_ROW_X_MAX:  prdata = {8'd0, row_x_max_reg};
            arcl_pkg::ADDR_SITE_PITCH: prdata = {16'd0, site_pitch_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 11'd0;
            out_valid_reg <= 1'b0;
            mstep_reg     <= 2'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_data;
                        w_reg    <= in_data.cell_width * in_data.cell_height;
                        if (in_data.req_type == arcl_pkg::REQ_CLEAR)
                        begin
                            count_reg <= 11'd0;
                            state_reg <= S_ZERO;
                        end
                        else if (in_data.req_type == arcl_pkg::REQ_NONE)
                            state_reg <= S_ZERO;
                        else
                            state_reg <= S_RDTOP;
                    end
                end
                S_RDTOP: state_reg <= S_TOP;
                S_TOP:
                begin
                    if (count_reg == 11'd0 || prv_end < {1'b0, item_reg.cell_x})
                    begin
                        q_reg    <= 64'd0;
                        wt_reg   <= '0;
                        wd_reg   <= 25'd0;
                        last_reg <= (count_reg == 11'd0) ? 10'd0 : rd_reg.tail_idx + 10'd1;
                        prev_reg <= $signed({1'b0, count_reg}) - 12'sd1;
                    end
                    else
                    begin
                        q_reg    <= rd_reg.q;
                        wt_reg   <= {11'd0, rd_reg.weight};
                        wd_reg   <= {1'b0, rd_reg.width};
                        last_reg <= rd_reg.tail_idx + 10'd1;
                        prev_reg <= $signed({1'b0, count_reg}) - 12'sd2;
                    end
                    mstep_reg <= 2'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // q += w*cx - w*wd, two products in turn
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd0)
                        pa_reg <= {12'd0, mul_wx};
                    else if (mstep_reg == 2'd1)
                        pb_reg <= {11'd0, mul_wd};
                    else
                    begin
                        q_reg     <= q_reg + pa_reg - pb_reg;
                        wt_reg    <= wt_reg + {23'd0, w_reg};
                        wd_reg    <= wd_reg + {9'd0, item_reg.cell_width};
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if ($signed({1'b0, wd_reg}) > span)
                        state_reg <= S_ZERO;
                    else if (wt_reg == '0)
                    begin
                        x_reg     <= $signed({42'd0, row_x_min_reg});
                        state_reg <= S_SNAP;
                    end
                    else
                        state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        if (quo_s > Lim)
                            x_reg <= Lim;
                        else if (quo_s < -Lim)
                            x_reg <= -Lim;
                        else
                            x_reg <= quo_s;
                        state_reg <= S_SNAP;
                    end
                end
                S_SNAP:
                begin
                    if (x_reg >= $signed({42'd0, row_x_min_reg}))
                        state_reg <= S_DIV2;
                    else
                    begin
                        x_reg     <= $signed({42'd0, row_x_min_reg});
                        state_reg <= S_CLAMP;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        x_reg <= $signed({42'd0, row_x_min_reg})
                                 + $signed({9'd0, snap_prod});
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP:
                begin
                    if (x_reg > $signed({{40{hi[25]}}, hi}))
                        x_reg <= $signed({{40{hi[25]}}, hi});
                    state_reg <= (prev_reg >= 12'sd0) ? S_PRV : S_FIN;
                end
                S_RDPRV: state_reg <= S_PRV;
                S_PRV:
                begin
                    if ($signed({41'd0, prv_end}) > x_reg)
                    begin
                        mstep_reg <= 2'd0;
                        state_reg <= S_MERGE;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_MERGE:
                begin
                    // wt * width in two halves, then fold in the earlier cluster
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd0)
                        pb_reg <= {14'd0, mul_lo};
                    else if (mstep_reg == 2'd1)
                        pb_reg <= pb_reg + {mul_hi[37:0], 26'd0};
                    else
                    begin
                        q_reg     <= rd_reg.q + q_reg - pb_reg;
                        wt_reg    <= wt_reg + {11'd0, rd_reg.weight};
                        wd_reg    <= wd_reg + {1'b0, rd_reg.width};
                        prev_reg  <= prev_reg - 12'sd1;
                        state_reg <= S_CHK;
                    end
                end
                S_FIN:
                begin
                    if (prev_reg >= 12'sd1023)
                        state_reg <= S_ZERO;
                    else
                    begin
                        if (item_reg.req_type == arcl_pkg::REQ_COMMIT)
                            count_reg <= 11'(prev_reg + 12'sd2);
                        rel_reg <= x_reg + $signed({41'd0, wd_reg})
                                   - $signed({50'd0, item_reg.cell_width});
                        state_reg <= S_COST;
                    end
                end
                S_COST:
                begin
                    // displacement magnitude
                    if (rel_reg - $signed({42'd0, item_reg.cell_x}) < 0)
                        pa_reg <= 64'($signed({42'd0, item_reg.cell_x}) - rel_reg);
                    else
                        pa_reg <= 64'(rel_reg - $signed({42'd0, item_reg.cell_x}));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_reg.placed       <= 1'b1;
                    out_reg.cell_new_x   <= rel_reg[23:0];
                    out_reg.cluster_x    <= x_reg[23:0];
                    out_reg.cluster_slot <= 10'(prev_reg + 12'sd1);
                    out_reg.x_cost       <= cost_sq[48:0];
                    out_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                S_ZERO:
                begin
                    out_reg       <= '0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the divider finishes only in a divide state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divider done outside divide state");

    // stack never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 11'(arcl_pkg::MaxCells))
        else $error("stack count overflow");

    // no new transaction while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input taken while result pending");

endmodule

@@ dv/tb_abacus_row_cluster_legalizer.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_abacus_row_cluster_legalizer
// Self-checking bench for the row cluster legalizer. A queue-fed driver
// sends cells, and each accepted transaction goes through a local cluster
// stack predictor. A monitor compares every result with the oldest
// prediction. Register settings change between drained phases. Both sides
// insert random idle bursts, and there is one long output hold.
// ============================================================================
module tb_abacus_row_cluster_legalizer;

    localparam longint     CYCLE_LIMIT = 20000000;
    localparam int         LONG_HOLD = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    arcl_pkg::in_item_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    arcl_pkg::out_item_t out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    abacus_row_cluster_legalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    arcl_pkg::in_item_t  pending_cells[$];
    arcl_pkg::out_item_t expected_placements[$];
    int        error_count = 0;
    bit        calm = 1'b0;
    bit        long_hold_req = 1'b0;
    bit        long_hold_done = 1'b0;
    int        long_hold_cnt = 0;
    int        send_gap = 0;
    int        stall_cnt = 0;
    longint    cycle_cnt = 0;

    // predictor configuration and cluster stack
    longint      cfg_row_min = 0;
    longint      cfg_row_max = 24'hFFFFFF;
    longint      cfg_site = 1;
    logic [63:0] stk_q[arcl_pkg::MaxCells];
    logic [39:0] stk_weight[arcl_pkg::MaxCells];
    logic [23:0] stk_width[arcl_pkg::MaxCells];
    logic [23:0] stk_pos[arcl_pkg::MaxCells];
    logic [9:0]  stk_last[arcl_pkg::MaxCells];
    int          stk_depth = 0;

    // divide, snap to site grid, clamp to the row
    function automatic longint cluster_position(logic [63:0] q, longint unsigned wt,
                                                longint wd);
        longint lo;
        longint hi;
        longint site;
        longint x;
        lo = cfg_row_min;
        hi = cfg_row_max - wd;
        site = (cfg_site != 0) ? cfg_site : 1;
        x = (wt != 0) ? $signed(q) / longint'(wt) : lo;
        if (x > (longint'(1) <<< 40)) x = longint'(1) <<< 40;
        if (x < -(longint'(1) <<< 40)) x = -(longint'(1) <<< 40);
        if (x >= lo) x = lo + (x - lo) / site * site;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    // append the cell, collapse backwards, store on commit
    function automatic arcl_pkg::out_item_t legalize_cell(arcl_pkg::in_item_t c);
        arcl_pkg::out_item_t r;
        longint unsigned w;
        logic [63:0]     q;
        longint unsigned wt;
        longint          wd;
        logic [9:0]      last;
        int              n;
        int              prev;
        longint          x;
        longint          newx;
        longint          d;
        longint unsigned sq;
        bit              done;
        r = '0;
        if (c.req_type == arcl_pkg::REQ_CLEAR)
        begin
            stk_depth = 0;
            return r;
        end
        if (c.req_type == arcl_pkg::REQ_NONE) return r;
        n = stk_depth;
        w = longint'(c.cell_width) * longint'(c.cell_height);
        if (n == 0 || longint'(stk_pos[n-1]) + longint'(stk_width[n-1]) < c.cell_x)
        begin
            q = '0;
            wt = 0;
            wd = 0;
            last = (n != 0) ? stk_last[n-1] + 10'd1 : 10'd0;
            prev = n - 1;
        end
        else
        begin
            q = stk_q[n-1];
            wt = stk_weight[n-1];
            wd = stk_width[n-1];
            last = stk_last[n-1] + 10'd1;
            prev = n - 2;
        end
        q = q + w * longint'(c.cell_x) - w * longint'(wd);
        wt = wt + w;
        wd = wd + c.cell_width;
        done = 1'b0;
        while (!done)
        begin
            if (wd > cfg_row_max - cfg_row_min) return r;
            x = cluster_position(q, wt, wd);
            if (prev >= 0 && longint'(stk_pos[prev]) + longint'(stk_width[prev]) > x)
            begin
                q = stk_q[prev] + q - wt * longint'(stk_width[prev]);
                wt = wt + stk_weight[prev];
                wd = wd + stk_width[prev];
                prev--;
            end
            else
                done = 1'b1;
        end
        if (prev + 1 >= arcl_pkg::MaxCells) return r;
        newx = x + wd - c.cell_width;
        d = newx - c.cell_x;
        if (d < 0) d = -d;
        sq = d * d;
        r.placed = 1'b1;
        r.cell_new_x = newx[23:0];
        r.cluster_x = x[23:0];
        r.cluster_slot = 10'(prev + 1);
        r.x_cost = sq[48:0];
        if (c.req_type == arcl_pkg::REQ_COMMIT)
        begin
            stk_q[prev+1] = q;
            stk_weight[prev+1] = wt[39:0];
            stk_width[prev+1] = wd[23:0];
            stk_pos[prev+1] = x[23:0];
            stk_last[prev+1] = last;
            stk_depth = prev + 2;
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // driver: feed cells from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_placements.insert(expected_placements.size(),
                                           legalize_cell(in_data));
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cells.size() != 0)
                begin
                    in_data <= pending_cells.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 15) == 0)
                        send_gap <= $urandom_range(1, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check results, drive output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_placements.size() == 0)
                begin
                    $error("unexpected transaction on output");
                    error_count++;
                end
                else
                begin
                    arcl_pkg::out_item_t e;
                    e = expected_placements.pop_front();
                    check_field("placed", e.placed, out_data.placed);
                    check_field("cell_new_x", e.cell_new_x, out_data.cell_new_x);
                    check_field("cluster_x", e.cluster_x, out_data.cluster_x);
                    check_field("cluster_slot", e.cluster_slot, out_data.cluster_slot);
                    check_field("x_cost", e.x_cost, out_data.x_cost);
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                out_stall <= 1'b1;
                long_hold_cnt <= long_hold_cnt + 1;
                if (long_hold_cnt == LONG_HOLD - 1) long_hold_done <= 1'b1;
            end
            else if (stall_cnt != 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                stall_cnt <= $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("abacus_row_cluster_legalizer verification failed");
            $finish;
        end
    end

    task automatic queue_cell(logic [1:0] req, longint x, longint w, longint h);
        arcl_pkg::in_item_t c;
        c.req_type = req;
        c.cell_x = x[23:0];
        c.cell_width = w[15:0];
        c.cell_height = h[11:0];
        pending_cells.insert(pending_cells.size(), c);
    endtask

    // wait until every cell is sent and every result is back
    task automatic drain();
        while (pending_cells.size() != 0 || in_valid || expected_placements.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            arcl_pkg::ADDR_ROW_X_MIN:  cfg_row_min = value[23:0];
            arcl_pkg::ADDR_ROW_X_MAX:  cfg_row_max = value[23:0];
            arcl_pkg::ADDR_SITE_PITCH: cfg_site = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(longint lo, longint hi, longint site);
        write_reg(arcl_pkg::ADDR_ROW_X_MIN, lo[31:0]);
        write_reg(arcl_pkg::ADDR_ROW_X_MAX, hi[31:0]);
        write_reg(arcl_pkg::ADDR_SITE_PITCH, site[31:0]);
    endtask

    // clear then runs of nearby cells, mostly commits, some noise
    task automatic random_cells(int count);
        int     sent;
        int     k;
        longint span;
        longint x;
        longint w;
        longint h;
        logic [1:0] req;
        sent = 0;
        span = (cfg_row_max > cfg_row_min) ? cfg_row_max - cfg_row_min : 1;
        while (sent < count)
        begin
            queue_cell(arcl_pkg::REQ_CLEAR, $urandom, $urandom, $urandom);
            sent++;
            x = cfg_row_min + ($urandom % span);
            k = $urandom_range(1, 12);
            repeat (k)
            begin
                x = x + $urandom_range(0, 60) - 30;
                if (x < 0) x = 0;
                if (x > 24'hFFFFFF) x = 24'hFFFFFF;
                w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 40);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1, 8);
                req = ($urandom_range(0, 3) == 0) ? arcl_pkg::REQ_TRY
                                                  : arcl_pkg::REQ_COMMIT;
                if ($urandom_range(0, 19) == 0)
                    queue_cell(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    queue_cell(req, $urandom, w, h);
                else
                    queue_cell(req, x, w, h);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-row extremes
        configure(0, 24'hFFFFFF, 1);
        queue_cell(arcl_pkg::REQ_TRY, 0, 1, 1);
        queue_cell(arcl_pkg::REQ_COMMIT, 24'hFFFFFF, 1, 1);
        queue_cell(arcl_pkg::REQ_COMMIT, 100, 65535, 4095);
        queue_cell(arcl_pkg::REQ_COMMIT, 200, 10, 3);
        queue_cell(arcl_pkg::REQ_TRY, 150, 20, 4095);
        queue_cell(arcl_pkg::REQ_COMMIT, 150, 5, 0);      // zero weight cell
        queue_cell(arcl_pkg::REQ_NONE, 24'hFFFFFF, 16'hFFFF, 12'hFFF);
        queue_cell(arcl_pkg::REQ_COMMIT, 24'hFFFFFF, 16'hFFFF, 12'hFFF);
        queue_cell(arcl_pkg::REQ_CLEAR, 0, 0, 0);
        queue_cell(arcl_pkg::REQ_COMMIT, 500, 0, 7);      // zero width cell
        queue_cell(arcl_pkg::REQ_COMMIT, 498, 30, 2);
        queue_cell(arcl_pkg::REQ_COMMIT, 499, 30, 2);
        queue_cell(arcl_pkg::REQ_TRY, 24'hAAAAAA, 16'h5555, 12'hAAA);
        queue_cell(arcl_pkg::REQ_TRY, 24'h555555, 16'hAAAA, 12'h555);
        queue_cell(arcl_pkg::REQ_CLEAR, 0, 0, 0);
        drain();

        // fill the stack to overflow
        for (int i = 0; i <= arcl_pkg::MaxCells; i++)
            queue_cell(arcl_pkg::REQ_COMMIT, 3 * i, 1, 1);
        queue_cell(arcl_pkg::REQ_TRY, 4000, 1, 1);
        queue_cell(arcl_pkg::REQ_CLEAR, 0, 0, 0);
        random_cells(150);
        drain();

        // narrow row with site snap, long output hold
        configure(1000, 300000, 8);
        long_hold_req = 1'b1;
        random_cells(250);
        drain();

        // empty and inverted rows
        configure(24'hFFFFFF, 24'hFFFFFF, 65535);
        queue_cell(arcl_pkg::REQ_COMMIT, 24'hFFFFFF, 1, 1);
        queue_cell(arcl_pkg::REQ_TRY, 0, 0, 0);
        drain();
        configure(5000, 2000, 1);
        queue_cell(arcl_pkg::REQ_COMMIT, 3000, 1, 1);
        queue_cell(arcl_pkg::REQ_TRY, 5000, 0, 1);
        drain();

        // coarsest site, then zero site width
        configure(0, 24'hFFFFFF, 65535);
        random_cells(150);
        drain();
        configure(77, 1000000, 0);
        random_cells(100);
        drain();

        // final stretch with no idling
        configure(200, 90000, 3);
        calm = 1'b1;
        random_cells(300);
        drain();
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("abacus_row_cluster_legalizer verification clean");
        else
            $display("abacus_row_cluster_legalizer verification failed");
        $finish;
    end

endmodule

@@ abacus_row_cluster_legalizer.f @@
sv/arcl_pkg.sv
sv/arcl_div.sv
sv/abacus_row_cluster_legalizer.sv
dv/tb_abacus_row_cluster_legalizer.sv
